/* hw/rtl/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // Fixed field widths
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned COLOR_W      = 4;
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned CELL_W       = 16;
  localparam int unsigned CURSOR_COL_W = 7;
  localparam int unsigned CURSOR_ROW_W = 5;
  localparam int unsigned CURSOR_IDX_W = 11;
  localparam int unsigned S_TDATA_W    = 32;
  localparam int unsigned M_TDATA_W    = 40;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  // space in light grey on black
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT_CHAR   = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ_CELL  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_sweep;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tcw_ctrl.sv */
`default_nettype none

module tcw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire tcw_pkg::dp_sts_t   sts_i,
  output tcw_pkg::ctrl_cmd_t      cmd_o
);

  tcw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_INIT: begin
        if (sts_i.sweep_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        state_d = sts_i.needs_sweep ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_SWEEP: begin
        if (sts_i.sweep_last) state_d = tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = s_valid_i ? tcw_pkg::ST_EXEC : tcw_pkg::ST_IDLE;
        end
      end
      default: state_d = tcw_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    s_ready_o = (state_q == tcw_pkg::ST_IDLE) ||
                ((state_q == tcw_pkg::ST_RESP) && sts_i.out_free);
    cmd_o.capture  = s_valid_i && s_ready_o;
    cmd_o.exec     = (state_q == tcw_pkg::ST_EXEC);
    cmd_o.sweep    = (state_q == tcw_pkg::ST_INIT) || (state_q == tcw_pkg::ST_SWEEP);
    cmd_o.load_out = (state_q == tcw_pkg::ST_RESP) && sts_i.out_free;
  end

endmodule

`default_nettype wire

/* hw/rtl/tcw_datapath.sv */
`default_nettype none

module tcw_datapath #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tcw_pkg::ctrl_cmd_t                cmd_i,
  output tcw_pkg::dp_sts_t                       sts_o,
  input  wire logic [tcw_pkg::OPCODE_W-1:0]      opcode_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]        char_code_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]       fg_color_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]       bg_color_i,
  input  wire logic [tcw_pkg::COORD_W-1:0]       col_i,
  input  wire logic [tcw_pkg::COORD_W-1:0]       row_i,
  input  wire logic                              m_ready_i,
  output logic                                   m_valid_o,
  output logic [tcw_pkg::CURSOR_COL_W-1:0]       cursor_col_o,
  output logic [tcw_pkg::CURSOR_ROW_W-1:0]       cursor_row_o,
  output logic [tcw_pkg::CURSOR_IDX_W-1:0]       cursor_index_o,
  output logic [tcw_pkg::CHAR_W-1:0]             cell_char_o,
  output logic [tcw_pkg::CHAR_W-1:0]             cell_attr_o
);

  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);
  localparam int unsigned AW1        = ADDR_W + 1;
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned ROW_W      = $clog2(ROWS);

  // captured item
  tcw_pkg::opcode_e             op_q;
  logic [tcw_pkg::CHAR_W-1:0]   char_q;
  logic [tcw_pkg::CHAR_W-1:0]   attr_q;
  logic [COL_W-1:0]             arg_col_q;
  logic [ROW_W-1:0]             arg_row_q;

  // cursor and scroll origin (physical row holding logical row 0)
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [ROW_W-1:0]  base_q, base_d;
  logic [ADDR_W-1:0] base_addr_q, base_addr_d;

  logic [ADDR_W-1:0] sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0] sweep_last_q, sweep_last_d;

  logic [tcw_pkg::CELL_W-1:0] mem [CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] rd_data_q;

  logic                                  out_valid_q;
  logic [tcw_pkg::CURSOR_COL_W-1:0]      out_col_q;
  logic [tcw_pkg::CURSOR_ROW_W-1:0]      out_row_q;
  logic [tcw_pkg::CURSOR_IDX_W-1:0]      out_idx_q;
  logic [tcw_pkg::CHAR_W-1:0]            out_char_q;
  logic [tcw_pkg::CHAR_W-1:0]            out_attr_q;

  logic is_newline, last_col, last_row, write_cell, next_line, scroll;
  logic [COL_W-1:0]  col_sel;
  logic [ROW_W-1:0]  row_sel;
  logic [AW1-1:0]    lin_addr, phys_sum, cur_lin;
  logic [ADDR_W-1:0] cell_addr;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;

  // ---------------- item capture ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= tcw_pkg::opcode_e'(opcode_i);
      char_q    <= char_code_i;
      attr_q    <= {bg_color_i, fg_color_i};
      arg_col_q <= (col_i >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1) : col_i[COL_W-1:0];
      arg_row_q <= (row_i >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : row_i[ROW_W-1:0];
    end
  end

  // ---------------- execute ----------------
  always_comb begin
    is_newline = (char_q == tcw_pkg::NEWLINE_CHAR);
    last_col   = (cur_col_q == COL_W'(COLUMNS - 1));
    last_row   = (cur_row_q == ROW_W'(ROWS - 1));
    write_cell = (op_q == tcw_pkg::OP_PUT_CHAR) && !is_newline;
    next_line  = (op_q == tcw_pkg::OP_PUT_CHAR) && (is_newline || last_col);
    scroll     = next_line && last_row;

    // logical cell -> physical address, rotated by the scroll origin
    col_sel   = (op_q == tcw_pkg::OP_READ_CELL) ? arg_col_q : cur_col_q;
    row_sel   = (op_q == tcw_pkg::OP_READ_CELL) ? arg_row_q : cur_row_q;
    lin_addr  = AW1'(row_sel) * AW1'(COLUMNS) + AW1'(col_sel);
    phys_sum  = lin_addr + AW1'(base_addr_q);
    cell_addr = (phys_sum >= AW1'(CELL_COUNT)) ? ADDR_W'(phys_sum - AW1'(CELL_COUNT))
                                               : phys_sum[ADDR_W-1:0];
  end

  always_comb begin
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    base_d      = base_q;
    base_addr_d = base_addr_q;
    if (cmd_i.exec) begin
      case (op_q)
        tcw_pkg::OP_PUT_CHAR: begin
          if (next_line) begin
            cur_col_d = '0;
            if (!last_row) cur_row_d = cur_row_q + ROW_W'(1);
          end else begin
            cur_col_d = cur_col_q + COL_W'(1);
          end
          // scroll: old top physical row becomes the new bottom row
          if (scroll) begin
            base_d      = (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + ROW_W'(1);
            base_addr_d = (base_addr_q == ADDR_W'(CELL_COUNT - COLUMNS)) ? '0
                          : base_addr_q + ADDR_W'(COLUMNS);
          end
        end
        tcw_pkg::OP_SET_CURSOR: begin
          cur_col_d = arg_col_q;
          cur_row_d = arg_row_q;
        end
        tcw_pkg::OP_CLEAR: begin
          cur_col_d   = '0;
          cur_row_d   = '0;
          base_d      = '0;
          base_addr_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      base_q      <= '0;
      base_addr_q <= '0;
    end else begin
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      base_q      <= base_d;
      base_addr_q <= base_addr_d;
    end
  end

  // ---------------- blanking sweep ----------------
  always_comb begin
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    if (cmd_i.exec && (op_q == tcw_pkg::OP_CLEAR)) begin
      sweep_addr_d = '0;
      sweep_last_d = ADDR_W'(CELL_COUNT - 1);
    end else if (cmd_i.exec && scroll) begin
      sweep_addr_d = base_addr_q;
      sweep_last_d = base_addr_q + ADDR_W'(COLUMNS - 1);
    end else if (cmd_i.sweep && (sweep_addr_q != sweep_last_q)) begin
      sweep_addr_d = sweep_addr_q + ADDR_W'(1);
    end
  end

  // reset value starts the power-up clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      sweep_last_q <= ADDR_W'(CELL_COUNT - 1);
    end else begin
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
    end
  end

  // ---------------- screen store ----------------
  always_comb begin
    mem_we    = cmd_i.sweep || (cmd_i.exec && write_cell);
    mem_waddr = cmd_i.sweep ? sweep_addr_q : cell_addr;
    mem_wdata = cmd_i.sweep ? tcw_pkg::BLANK_CELL : {attr_q, char_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.exec) rd_data_q <= mem[cell_addr];
  end

  // ---------------- result register ----------------
  always_comb begin
    cur_lin = AW1'(cur_row_q) * AW1'(COLUMNS) + AW1'(cur_col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_col_q <= tcw_pkg::CURSOR_COL_W'(cur_col_q);
      out_row_q <= tcw_pkg::CURSOR_ROW_W'(cur_row_q);
      out_idx_q <= tcw_pkg::CURSOR_IDX_W'(cur_lin);
      if (op_q == tcw_pkg::OP_READ_CELL) begin
        out_char_q <= rd_data_q[7:0];
        out_attr_q <= rd_data_q[15:8];
      end else begin
        out_char_q <= '0;
        out_attr_q <= '0;
      end
    end
  end

  always_comb begin
    sts_o.needs_sweep = (op_q == tcw_pkg::OP_CLEAR) || scroll;
    sts_o.sweep_last  = (sweep_addr_q == sweep_last_q);
    sts_o.out_free    = !out_valid_q || m_ready_i;
    m_valid_o      = out_valid_q;
    cursor_col_o   = out_col_q;
    cursor_row_o   = out_row_q;
    cursor_index_o = out_idx_q;
    cell_char_o    = out_char_q;
    cell_attr_o    = out_attr_q;
  end

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_col_q) < COLUMNS) && (32'(cur_row_q) < ROWS))
    else $error("cursor outside screen");

  a_base_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(base_q) < ROWS) && (32'(base_addr_q) == 32'(base_q) * COLUMNS))
    else $error("scroll origin row and address disagree");

  a_sweep_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep |-> (sweep_addr_q <= sweep_last_q) && (32'(sweep_last_q) < CELL_COUNT))
    else $error("blanking sweep out of bounds");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || m_ready_i))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

/* hw/rtl/text_console_writer_unit.sv */
// Channel  Dir  tdata                                       tuser
// s_axis   in   char_code, fg_color, bg_color, col, row     opcode
// m_axis   out  cursor_col, cursor_row, cursor_index,       -
//               cell_char, cell_attr
//
// An item is accepted, then executed in the execute state with a single store
// access; the result leaves from an output register. A new item is accepted as the result is loaded.
// A scroll adds a blanking sweep (one blank write per cell of the recycled row),
// a clear one over all COLUMNS*ROWS cells, bound by the store's single write port.
// After reset a clearing pass over all cells runs with s_axis_tready_o low.
// A stalled result holds; one further item is accepted and waits behind it.
`default_nettype none

module text_console_writer_unit #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // char_code[7:0], fg_color[11:8], bg_color[15:12], col[23:16], row[31:24]
  input  wire logic [tcw_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [tcw_pkg::OPCODE_W-1:0]   s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // cursor_col[6:0], cursor_row[11:7], cursor_index[22:12], cell_char[30:23],
  // cell_attr[38:31], zero[39]
  output logic [tcw_pkg::M_TDATA_W-1:0]       m_axis_tdata_o
);

  tcw_pkg::ctrl_cmd_t cmd;
  tcw_pkg::dp_sts_t   sts;

  logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col;
  logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row;
  logic [tcw_pkg::CURSOR_IDX_W-1:0] cursor_index;
  logic [tcw_pkg::CHAR_W-1:0]       cell_char;
  logic [tcw_pkg::CHAR_W-1:0]       cell_attr;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (s_axis_tuser_i),
    .char_code_i    (s_axis_tdata_i[7:0]),
    .fg_color_i     (s_axis_tdata_i[11:8]),
    .bg_color_i     (s_axis_tdata_i[15:12]),
    .col_i          (s_axis_tdata_i[23:16]),
    .row_i          (s_axis_tdata_i[31:24]),
    .m_ready_i      (m_axis_tready_i),
    .m_valid_o      (m_axis_tvalid_o),
    .cursor_col_o   (cursor_col),
    .cursor_row_o   (cursor_row),
    .cursor_index_o (cursor_index),
    .cell_char_o    (cell_char),
    .cell_attr_o    (cell_attr)
  );

  assign m_axis_tdata_o = {1'b0, cell_attr, cell_char, cursor_index, cursor_row, cursor_col};

endmodule

`default_nettype wire

/* verif/text_console_writer_unit_test.sv */
`timescale 1ns / 100ps

module text_console_writer_unit_test;

  localparam int unsigned SCR_COLS     = tcw_pkg::COLUMNS_DEF;
  localparam int unsigned SCR_ROWS     = tcw_pkg::ROWS_DEF;
  localparam int unsigned SCR_CELLS    = SCR_COLS * SCR_ROWS;
  localparam int unsigned RANDOM_ITEMS = 1800;
  // a clear walks the whole store; allow several times that with no handshake
  localparam int unsigned STALL_LIMIT  = 4 * SCR_CELLS + 200;

  typedef struct {
    logic [tcw_pkg::CURSOR_COL_W-1:0] cursor_col;
    logic [tcw_pkg::CURSOR_ROW_W-1:0] cursor_row;
    logic [tcw_pkg::CURSOR_IDX_W-1:0] cursor_index;
    logic [tcw_pkg::CHAR_W-1:0]       cell_char;
    logic [tcw_pkg::CHAR_W-1:0]       cell_attr;
  } console_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [tcw_pkg::S_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic [tcw_pkg::OPCODE_W-1:0]   s_axis_tuser_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [tcw_pkg::M_TDATA_W-1:0]  m_axis_tdata_o;

  // shadow of the screen store and cursor
  logic [tcw_pkg::CELL_W-1:0]     shadow_cells [SCR_CELLS];
  int unsigned                    shadow_col;
  int unsigned                    shadow_row;

  console_result_t       pending_results[$];
  int unsigned           error_count = 0;
  int unsigned           items_sent = 0;
  int unsigned           quiet_cycles = 0;
  bit                    no_idle = 1'b0;

  always #10 clk_i = ~clk_i;

  text_console_writer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic int unsigned clamp_coord(logic [tcw_pkg::COORD_W-1:0] v,
                                              int unsigned limit);
    return (32'(v) >= limit) ? limit - 1 : 32'(v);
  endfunction

  function automatic void blank_screen();
    for (int unsigned i = 0; i < SCR_CELLS; i++) shadow_cells[i] = tcw_pkg::BLANK_CELL;
  endfunction

  function automatic void advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= SCR_ROWS) begin
      for (int unsigned i = 0; i < SCR_CELLS - SCR_COLS; i++)
        shadow_cells[i] = shadow_cells[i + SCR_COLS];
      for (int unsigned i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
        shadow_cells[i] = tcw_pkg::BLANK_CELL;
      shadow_row = SCR_ROWS - 1;
    end
  endfunction

  function automatic console_result_t console_predict(tcw_pkg::opcode_e op, logic [7:0] ch,
                                                      logic [3:0] fg, logic [3:0] bg,
                                                      logic [7:0] col, logic [7:0] row);
    console_result_t res;
    int unsigned     idx;
    res.cell_char = '0;
    res.cell_attr = '0;
    case (op)
      tcw_pkg::OP_PUT_CHAR: begin
        if (ch == tcw_pkg::NEWLINE_CHAR) begin
          advance_line();
        end else begin
          shadow_cells[shadow_row * SCR_COLS + shadow_col] = {bg, fg, ch};
          shadow_col++;
          if (shadow_col >= SCR_COLS) advance_line();
        end
      end
      tcw_pkg::OP_SET_CURSOR: begin
        shadow_col = clamp_coord(col, SCR_COLS);
        shadow_row = clamp_coord(row, SCR_ROWS);
      end
      tcw_pkg::OP_CLEAR: begin
        blank_screen();
        shadow_col = 0;
        shadow_row = 0;
      end
      default: begin
        idx = clamp_coord(row, SCR_ROWS) * SCR_COLS + clamp_coord(col, SCR_COLS);
        res.cell_char = shadow_cells[idx][7:0];
        res.cell_attr = shadow_cells[idx][15:8];
      end
    endcase
    res.cursor_col   = shadow_col[tcw_pkg::CURSOR_COL_W-1:0];
    res.cursor_row   = shadow_row[tcw_pkg::CURSOR_ROW_W-1:0];
    idx              = shadow_row * SCR_COLS + shadow_col;
    res.cursor_index = idx[tcw_pkg::CURSOR_IDX_W-1:0];
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(tcw_pkg::opcode_e op, logic [7:0] ch, logic [3:0] fg,
                           logic [3:0] bg, logic [7:0] col, logic [7:0] row);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {row, col, bg, fg, ch};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(console_predict(op, ch, fg, bg, col, row));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_char(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
    send_item(tcw_pkg::OP_PUT_CHAR, ch, fg, bg, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic set_cursor(logic [7:0] col, logic [7:0] row);
    send_item(tcw_pkg::OP_SET_CURSOR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), col, row);
  endtask

  task automatic read_cell(logic [7:0] col, logic [7:0] row);
    send_item(tcw_pkg::OP_READ_CELL, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), col, row);
  endtask

  task automatic clear_screen();
    send_item(tcw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // hold the input off until every result is back
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // result side: random stalls per item
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    console_result_t want;
    logic [tcw_pkg::M_TDATA_W-1:0] d;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      d = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $error("unexpected result item, tdata %h", d);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (d[6:0] !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, d[6:0]);
          error_count++;
        end
        if (d[11:7] !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, d[11:7]);
          error_count++;
        end
        if (d[22:12] !== want.cursor_index) begin
          $error("cursor_index: expected %0d, got %0d", want.cursor_index, d[22:12]);
          error_count++;
        end
        if (d[30:23] !== want.cell_char) begin
          $error("cell_char: expected %h, got %h", want.cell_char, d[30:23]);
          error_count++;
        end
        if (d[38:31] !== want.cell_attr) begin
          $error("cell_attr: expected %h, got %h", want.cell_attr, d[38:31]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_contents();
    read_cell(8'd0, 8'd0);
    read_cell(8'd255, 8'd255);
  endtask

  task automatic test_put_char();
    put_char(8'h41, 4'hF, 4'hF);
    put_char(8'h00, 4'h0, 4'h0);
    put_char(8'hFF, 4'h5, 4'hA);
    read_cell(8'd0, 8'd0);
    read_cell(8'd2, 8'd0);
  endtask

  task automatic test_cursor_wrap();
    set_cursor(8'd200, 8'd30);
    set_cursor(8'd79, 8'd0);
    put_char(8'hBE, 4'h3, 4'hC);   // last column: wraps to next row
    put_char(tcw_pkg::NEWLINE_CHAR, 4'h9, 4'h6);
    read_cell(8'd79, 8'd0);
    read_cell(8'd0, 8'd1);         // newline left this cell blank
  endtask

  task automatic test_scroll();
    set_cursor(8'd255, 8'd255);
    put_char(8'h5A, 4'h1, 4'h2);   // wraps past the bottom row
    read_cell(8'd79, 8'd23);
    read_cell(8'd0, 8'd0);
    put_char(tcw_pkg::NEWLINE_CHAR, 4'h0, 4'h0);
    read_cell(8'd79, 8'd22);
  endtask

  task automatic test_clear();
    clear_screen();
    read_cell(8'd79, 8'd22);
  endtask

  task automatic test_random_traffic();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  ch;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        len = $urandom_range(1, 40);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0:       ch = tcw_pkg::NEWLINE_CHAR;
            1, 2:    ch = 8'($urandom_range(0, 255));
            default: ch = 8'($urandom_range(32, 126));
          endcase
          put_char(ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
      end else if (kind < 80) begin
        // bias toward the bottom rows so typing scrolls
        if ($urandom_range(0, 3) == 0)
          set_cursor(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
          set_cursor(8'($urandom_range(0, SCR_COLS - 1)),
                     8'($urandom_range(20, SCR_ROWS - 1)));
      end else if (kind < 95) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0)
            read_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          else
            read_cell(8'($urandom_range(0, SCR_COLS - 1)),
                      8'($urandom_range(0, SCR_ROWS - 1)));
        end
      end else if (kind < 98) begin
        wait_drained();
      end else begin
        clear_screen();
      end
    end
  endtask

  task automatic test_drain_pause();
    put_char(8'h7E, 4'hF, 4'h0);
    wait_drained();
    read_cell(8'd0, 8'd0);
  endtask

  initial begin
    blank_screen();
    shadow_col = 0;
    shadow_row = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_contents();
    test_put_char();
    test_cursor_wrap();
    test_scroll();
    test_clear();
    test_drain_pause();
    test_random_traffic();

    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
